/* sv/csm_pkg.sv */
// ----------------------------------------------------------------------------
// csm_pkg
// Shared widths, item codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int KIND_W  = 2;
	localparam int OP_W    = 4;
	localparam int NUM_W   = 31;
	localparam int LIM_W   = 30;
	localparam int PROD_W  = 2 * NUM_W;
	localparam int DCNT_W  = 5;

	localparam logic [LIM_W-1:0]  LIMIT_RESET = 30'd1000000000;
	localparam logic [DCNT_W-1:0] DIV_LAST    = 5'd30;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// opcodes
	localparam logic [OP_W-1:0] OP_NUM = 4'd0;
	localparam logic [OP_W-1:0] OP_POP = 4'd1;
	localparam logic [OP_W-1:0] OP_INV = 4'd2;
	localparam logic [OP_W-1:0] OP_DUP = 4'd3;
	localparam logic [OP_W-1:0] OP_SWP = 4'd4;
	localparam logic [OP_W-1:0] OP_ADD = 4'd5;
	localparam logic [OP_W-1:0] OP_SUB = 4'd6;
	localparam logic [OP_W-1:0] OP_MUL = 4'd7;
	localparam logic [OP_W-1:0] OP_DIV = 4'd8;
	localparam logic [OP_W-1:0] OP_MOD = 4'd9;

	typedef struct packed {
		logic load;     // capture accepted word, issue stack read
		logic exec;     // execute captured item
		logic div_run;  // one divider step
		logic fin;      // range check and write back
	} cmd_t;

	typedef struct packed {
		logic go_fin;
		logic go_div;
		logic div_last;
		logic out_busy;
	} st_t;

endpackage

/* sv/csm_ram.sv */
// ----------------------------------------------------------------------------
// csm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/csm_ctrl.sv */
// ----------------------------------------------------------------------------
// csm_ctrl
// Sequencer: accept, execute, optional divide loop, write back.
// ----------------------------------------------------------------------------
module csm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  csm_pkg::st_t  st,
	output csm_pkg::cmd_t cmd
);
	import csm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic       accept;

	assign s_tready = (state_q == S_IDLE) && !st.out_busy;
	assign accept   = s_tvalid && s_tready;

	assign cmd.load    = accept;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.div_run = (state_q == S_DIV);
	assign cmd.fin     = (state_q == S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (st.go_div)      state_q <= S_DIV;
					else if (st.go_fin) state_q <= S_FIN;
					else                state_q <= S_IDLE;
				end
				S_DIV: begin
					if (st.div_last) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC) else $error("accept did not enter execute");
	a_div_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && st.div_last) |=> state_q == S_FIN)
		else $error("divider end did not reach write back");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_IDLE) else $error("write back not single cycle");
endmodule

/* sv/csm_dp.sv */
// ----------------------------------------------------------------------------
// csm_dp
// Stack datapath: cached top, stack RAM, ALU, multiplier, serial divider.
// ----------------------------------------------------------------------------
module csm_dp #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csm_pkg::cmd_t                 cmd,
	output csm_pkg::st_t                  st,
	input  logic [csm_pkg::KIND_W-1:0]    s_tuser,
	input  logic [39:0]                   s_tdata,
	input  logic                          cfg_we,
	input  logic [csm_pkg::LIM_W-1:0]     cfg_wdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,
	output logic                          m_tuser
);
	import csm_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [KIND_W-1:0]       kind_q;
	logic [OP_W-1:0]         op_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [NUM_W-1:0] top_q;
	logic [CW-1:0]           count_q;
	logic                    err_q;
	logic [LIM_W-1:0]        limit_q;
	logic signed [PROD_W-1:0] res_q;
	logic [NUM_W-1:0]        quo_q, dvs_q;
	logic [NUM_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic                    a_neg_q, b_neg_q;
	logic [NUM_W-1:0]        out_val_q;
	logic                    out_stat_q;

	logic signed [NUM_W-1:0] sec;
	logic                    is_inst, has1, has2, full, is_div_op;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [NUM_W-1:0]        ram_wdata;
	logic signed [PROD_W-1:0] prod, alu;
	logic [NUM_W:0]          dtrial;
	logic                    dbit;
	logic [PROD_W-1:0]       mag;
	logic signed [NUM_W-1:0] fin_val;
	logic                    over;

	assign ram_raddr = AW'(count_q - CW'(2));

	csm_ram #(.WIDTH(NUM_W), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (sec)
	);

	assign is_inst   = (kind_q == KIND_INST) && !err_q;
	assign has1      = (count_q != '0);
	assign has2      = (count_q >= CW'(2));
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign is_div_op = (op_q == OP_DIV) || (op_q == OP_MOD);

	assign st.go_fin = is_inst && (((op_q == OP_INV) && has1) ||
		(((op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MUL)) && has2));
	assign st.go_div   = is_inst && is_div_op && has2 && (top_q != '0);
	assign st.div_last = (dcnt_q == DIV_LAST);
	assign st.out_busy = m_tvalid && !m_tready;

	// spill the cached top into RAM on push, swap the second entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q - CW'(1));
		ram_wdata = top_q;
		if (cmd.exec && is_inst) begin
			case (op_q)
				OP_NUM, OP_DUP: ram_we = has1 && !full && (op_q == OP_NUM || has1);
				OP_SWP: begin
					ram_we    = has2;
					ram_waddr = ram_raddr;
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	assign prod = sec * top_q;

	always_comb begin
		case (op_q)
			OP_INV:  alu = -PROD_W'(top_q);
			OP_ADD:  alu = PROD_W'(sec) + PROD_W'(top_q);
			OP_SUB:  alu = PROD_W'(sec) - PROD_W'(top_q);
			default: alu = prod;
		endcase
	end

	// restoring divide step on magnitudes
	assign dtrial = {rem_q, quo_q[NUM_W-1]};
	assign dbit   = (dtrial >= {1'b0, dvs_q});

	always_comb begin
		if (is_div_op) begin
			if (op_q == OP_DIV) begin
				mag     = PROD_W'(quo_q);
				fin_val = (a_neg_q ^ b_neg_q) ? -$signed(quo_q) : $signed(quo_q);
			end else begin
				mag     = PROD_W'(rem_q);
				fin_val = b_neg_q ? -$signed(rem_q) : $signed(rem_q);
			end
		end else begin
			mag     = res_q[PROD_W-1] ? PROD_W'(-res_q) : PROD_W'(res_q);
			fin_val = res_q[NUM_W-1:0];
		end
	end
	assign over = (mag > PROD_W'(limit_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tdata[OP_W-1:0];
			num_q <= s_tdata[OP_W +: NUM_W];
		end
		if (cmd.exec) begin
			res_q   <= alu;
			a_neg_q <= top_q[NUM_W-1];
			b_neg_q <= sec[NUM_W-1];
			dvs_q   <= top_q[NUM_W-1] ? NUM_W'(-top_q) : NUM_W'(top_q);
			quo_q   <= sec[NUM_W-1] ? NUM_W'(-sec) : NUM_W'(sec);
			rem_q   <= '0;
		end else if (cmd.div_run) begin
			rem_q <= dbit ? NUM_W'(dtrial - {1'b0, dvs_q}) : dtrial[NUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], dbit};
		end
		if (cmd.exec && kind_q == KIND_END) begin
			out_val_q  <= (err_q || count_q != CW'(1)) ? '0 : top_q;
			out_stat_q <= err_q || (count_q != CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_START;
			count_q  <= '0;
			err_q    <= 1'b0;
			limit_q  <= LIMIT_RESET;
			dcnt_q   <= '0;
			m_tvalid <= 1'b0;
			top_q    <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.load) kind_q <= s_tuser;
			if (cmd.exec && kind_q == KIND_END) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (cmd.exec) dcnt_q <= '0;
			else if (cmd.div_run) dcnt_q <= dcnt_q + DCNT_W'(1);

			if (cmd.exec) begin
				case (kind_q)
					KIND_START: begin
						count_q <= CW'(1);
						top_q   <= num_q;
						err_q   <= 1'b0;
					end
					KIND_END: begin
						count_q  <= '0;
						err_q    <= 1'b0;
					end
					KIND_INST: begin
						if (!err_q) begin
							case (op_q)
								OP_NUM: begin
									if (full) err_q <= 1'b1;
									else begin
										top_q   <= num_q;
										count_q <= count_q + CW'(1);
									end
								end
								OP_POP: begin
									if (!has1) err_q <= 1'b1;
									else begin
										top_q   <= sec;
										count_q <= count_q - CW'(1);
									end
								end
								OP_INV: begin
									if (!has1) err_q <= 1'b1;
								end
								OP_DUP: begin
									if (!has1 || full) err_q <= 1'b1;
									else count_q <= count_q + CW'(1);
								end
								OP_SWP: begin
									if (!has2) err_q <= 1'b1;
									else top_q <= sec;
								end
								OP_ADD, OP_SUB, OP_MUL: begin
									if (!has2) err_q <= 1'b1;
								end
								OP_DIV, OP_MOD: begin
									if (!has2 || top_q == '0) err_q <= 1'b1;
								end
								default: ;
							endcase
						end
					end
					default: ;
				endcase
			end

			if (cmd.fin) begin
				if (over) err_q <= 1'b1;
				else begin
					top_q <= fin_val;
					if (op_q != OP_INV) count_q <= count_q - CW'(1);
				end
			end
		end
	end

	assign m_tdata = {1'b0, out_val_q};
	assign m_tuser = out_stat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
endmodule

/* sv/checked_stack_machine_top.sv */
// Steps per item: accept with stack read, then execute; ADD/SUB/MUL/INV add a write-back
// step, and DIV/MOD run the one-bit-per-cycle divider before write back.
// Throughput: one item at a time; the sequencer holds s_tready low until done.
// The end-of-run word sits in an output register; a new item is taken once it drains.
// Reset (arst_n low): empty stack, error flag clear, limit 1000000000; RAM not cleared.
// ----------------------------------------------------------------------------
// checked_stack_machine_top
// Checked signed integer stack machine with stream input and output.
// ----------------------------------------------------------------------------
module checked_stack_machine_top #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [39:0]               s_tdata,   // opcode[3:0], number[34:4]
	input  logic [csm_pkg::KIND_W-1:0] s_tuser,  // kind[1:0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,   // result_value[30:0]
	output logic                      m_tuser,   // status[0]
	input  logic                      cfg_we,
	input  logic [csm_pkg::LIM_W-1:0] cfg_wdata  // magnitude_limit
);
	import csm_pkg::*;

	cmd_t cmd;
	st_t  st;

	csm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	csm_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule
